// File: src/first_unique_letter_stream_macros.svh
// assertion macros for the first unique letter stream block
// used by the top level, expects clk_i and rst_ni in scope
`ifndef FIRST_UNIQUE_LETTER_STREAM_MACROS_SVH
`define FIRST_UNIQUE_LETTER_STREAM_MACROS_SVH

// same-cycle implication
`define FULS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fuls: same-cycle check failed");

// next-cycle implication
`define FULS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fuls: next-cycle check failed");

`endif

// File: src/fuls_pkg.sv
// shared types and constants for the first unique letter stream block
// no dependencies
package fuls_pkg;

  localparam int LetterWidth     = 5;
  localparam int AlphabetDefault = 26;

  typedef logic [LetterWidth-1:0] letter_t;

  typedef struct packed {
    letter_t letter;
    logic    new_stream;
  } in_item_t;

  typedef struct packed {
    logic    found;
    letter_t unique_letter;
  } out_item_t;

  // item travelling down the cell row
  typedef struct packed {
    letter_t letter;
    logic    in_range;
    logic    clear;
    logic    hit;
    logic    found;
    letter_t ans;
  } token_t;

endpackage

// File: src/fuls_stream_if.sv
// valid/ready channel carrying one item of a given payload type
// depends on nothing, payload type given at instantiation
interface fuls_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/fuls_cell.sv
// one letter cell of the first-seen order row
// uses fuls_pkg::token_t, passes the item to its right neighbor each cycle while en_i is high
module fuls_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fuls_pkg::token_t tok_i,
  output logic            valid_o,
  output fuls_pkg::token_t tok_o
);

  logic              used_q, used_d;
  logic              dup_q, dup_d;
  fuls_pkg::letter_t letter_q, letter_d;
  logic              cur_used, cur_dup, match, claim;
  logic              valid_q;
  fuls_pkg::token_t  tok_q, tok_d;

  always_comb begin
    cur_used = tok_i.clear ? 1'b0 : used_q;
    cur_dup  = tok_i.clear ? 1'b0 : dup_q;
    match    = cur_used && tok_i.in_range && (letter_q == tok_i.letter);
    claim    = !cur_used && tok_i.in_range && !tok_i.hit;
    used_d   = cur_used | claim;
    dup_d    = cur_dup | match;
    letter_d = claim ? tok_i.letter : letter_q;
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | match | claim;
    if (!tok_i.found && used_d && !dup_d) begin
      tok_d.found = 1'b1;
      tok_d.ans   = letter_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      dup_q   <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        used_q <= used_d;
        dup_q  <= dup_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
      if (valid_i) begin
        letter_q <= letter_d;
      end
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

// File: src/first_unique_letter_stream.sv
// first unique letter stream: an accepted item passes through each of the ALPHABET letter cells in turn to the result
// throughput one item per cycle while the output is not stalled, set by the row of ALPHABET letter cells
// each cell handles an item, registers it and hands it on; a stalled output stalls the row
// reset clears all cell and item valid flags at once, no clearing pass
// depends on fuls_pkg, fuls_stream_if, fuls_cell, first_unique_letter_stream_macros.svh
`include "first_unique_letter_stream_macros.svh"

module first_unique_letter_stream #(
  parameter int ALPHABET = fuls_pkg::AlphabetDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fuls_stream_if.sink   in_i,
  fuls_stream_if.source out_o
);

  logic             en;
  logic             in_fire;
  logic             valid_chain [ALPHABET+1];
  fuls_pkg::token_t tok_chain   [ALPHABET+1];
  fuls_pkg::in_item_t  in_item;
  fuls_pkg::out_item_t out_item;

  assign in_item = in_i.payload;
  assign en      = !valid_chain[ALPHABET] || out_o.ready;
  assign in_i.ready = en;
  assign in_fire = in_i.valid && en;

  assign valid_chain[0] = in_i.valid;
  assign tok_chain[0]   = '{
    letter:   in_item.letter,
    in_range: int'(in_item.letter) < ALPHABET,
    clear:    in_item.new_stream,
    hit:      1'b0,
    found:    1'b0,
    ans:      '0
  };

  for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
    fuls_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_chain[g]),
      .tok_i   (tok_chain[g]),
      .valid_o (valid_chain[g+1]),
      .tok_o   (tok_chain[g+1])
    );
  end

  always_comb begin
    out_item.found         = tok_chain[ALPHABET].found;
    out_item.unique_letter = tok_chain[ALPHABET].ans;
  end

  assign out_o.valid   = valid_chain[ALPHABET];
  assign out_o.payload = out_item;

  `FULS_ASSERT_NOW(a_none_is_zero, out_o.valid && !out_item.found, out_item.unique_letter == '0)
  `FULS_ASSERT_NOW(a_ans_in_range, out_o.valid && out_item.found,
                   int'(out_item.unique_letter) < ALPHABET)
  `FULS_ASSERT_NEXT(a_fresh_claims_first,
                    in_fire && in_item.new_stream && tok_chain[0].in_range,
                    tok_chain[1].found && tok_chain[1].ans == $past(in_item.letter))

endmodule
